### sv/assert_macros.svh
// Concurrent assertion macros used by the top-level RTL file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check that a condition implies a consequence in the same cycle.
`define ASSERT_IMPLIES(label, clk, rst_n, cond, cons) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (cond) |-> (cons)) \
    else $error("assertion failed: same-cycle implication");

// Check that a condition implies a consequence in the next cycle.
`define ASSERT_NEXT(label, clk, rst_n, cond, cons) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (cond) |=> (cons)) \
    else $error("assertion failed: next-cycle implication");

`endif

### sv/pcsg_pkg.sv
// Shared constants for the pie chart sector geometry block.
package pcsg_pkg;

  localparam int COORD_BITS_DEF = 16;
  localparam int WORD_BITS      = 32;
  localparam int DIV_STEPS      = 32;
  localparam int SQRT_STEPS     = 16;
  localparam int ROOT_BITS      = 16;
  localparam int PER_BITS       = 10;
  localparam int FRONT_STAGES   = 10;

  localparam int FULL_MILLE     = 1000;
  localparam int THREEQ_MILLE   = 750;
  localparam int HALF_MILLE     = 500;
  localparam int QUARTER_MILLE  = 250;
  localparam int STEEP_LIMIT    = 120;
  localparam int MIN_RADIUS     = 10;

  // Quadrant codes (fraction / 250)
  localparam logic [2:0] QUAD_0 = 3'd0;
  localparam logic [2:0] QUAD_1 = 3'd1;
  localparam logic [2:0] QUAD_2 = 3'd2;
  localparam logic [2:0] QUAD_3 = 3'd3;
  localparam logic [2:0] QUAD_4 = 3'd4;

endpackage

### sv/pie_chart_sector_geometry.sv
// Throughput: one request per cycle; busy is always low since nothing stalls.
// Latency is set by ten front stages, two 32-stage dividers, two 16-stage roots
// and three glue/output stages per lane, both lanes running side by side.
// Reset (rst_n low, synchronous) clears all valid bits; payload is not reset.
// Results cannot be held off by the receiver.
`include "assert_macros.svh"

module pie_chart_sector_geometry import pcsg_pkg::*; #(
  parameter int COORD_BITS = COORD_BITS_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         start,
  output logic                         busy,
  input  logic signed [COORD_BITS-1:0] in_rect_left,
  input  logic signed [COORD_BITS-1:0] in_rect_top,
  input  logic signed [COORD_BITS-1:0] in_rect_right,
  input  logic signed [COORD_BITS-1:0] in_rect_bottom,
  input  logic [PER_BITS-1:0]          in_used_per_mille,
  input  logic [PER_BITS-1:0]          in_cache_per_mille,
  output logic                         out_valid,
  output logic signed [COORD_BITS-1:0] out_box_left,
  output logic signed [COORD_BITS-1:0] out_box_top,
  output logic signed [COORD_BITS-1:0] out_box_right,
  output logic signed [COORD_BITS-1:0] out_box_bottom,
  output logic signed [COORD_BITS-1:0] out_shadow_depth,
  output logic signed [COORD_BITS-1:0] out_centre_x,
  output logic signed [COORD_BITS-1:0] out_centre_y,
  output logic [COORD_BITS-1:0]        out_used_x,
  output logic signed [COORD_BITS:0]   out_used_y,
  output logic [COORD_BITS-1:0]        out_cache_x,
  output logic signed [COORD_BITS:0]   out_cache_y,
  output logic                         out_status
);

  localparam int CB  = COORD_BITS;
  localparam int GW  = CB + 4;
  localparam int PW  = GW + 2;
  localparam int NF  = FRONT_STAGES;
  localparam int LAT = NF + 2 * DIV_STEPS + 2 * SQRT_STEPS + 3;
  localparam logic [CB-1:0] RECIP = CB'(((64'd1 << (CB + 1)) + 64'd2) / 64'd3);
  localparam logic signed [GW-1:0] ONE_G = GW'(1);
  localparam logic signed [GW-1:0] MIN_R = GW'(MIN_RADIUS);

  typedef struct packed {
    logic [PER_BITS-1:0]  per;
    logic [2:0]           quad;
    logic [8:0]           r500;
    logic [7:0]           u;
    logic [7:0]           v;
    logic [16:0]          den;
    logic                 steep;
    logic [7:0]           wt;
    logic [WORD_BITS-1:0] a2;
    logic [WORD_BITS-1:0] b2;
    logic [WORD_BITS-1:0] p;
  } lane_f_t;

  typedef struct packed {
    logic signed [GW-1:0] left, top, right, bottom;
    logic signed [GW-1:0] h, w, th, bl, bt, shadow, ry, cx, cy, br, bb;
    logic                 neg;
    logic [CB-1:0]        mag2;
    logic [CB-1:0]        q3;
    logic [WORD_BITS-1:0] rx2, ry2;
    logic                 status;
    lane_f_t [1:0]        ln;
  } front_t;

  typedef struct packed {
    logic [CB-1:0]        bl, bt, br, bb, sh;
    logic signed [GW-1:0] cx, cy;
    logic                 status;
    logic [WORD_BITS-1:0] a2, b2;
    logic                 steep;
    logic [2:0]           quad;
    logic [ROOT_BITS-1:0] r1;
  } side_t;

  localparam int SB = $bits(side_t);

  function automatic logic signed [GW-1:0] half_tz(input logic signed [GW-1:0] x);
    logic signed [GW-1:0] t;
    t = x + $signed({{(GW-1){1'b0}}, x[GW-1]});
    return t >>> 1;
  endfunction

  function automatic logic [WORD_BITS-1:0] lo32(input logic signed [GW-1:0] x);
    logic signed [63:0] e;
    e = 64'(x);
    return e[WORD_BITS-1:0];
  endfunction

  // the pipeline never stalls
  assign busy = 1'b0;

  // ---------------- front stages ----------------
  front_t st_r   [1:NF];
  front_t st_nxt [1:NF];
  logic   v_r    [1:NF];

  always_comb begin
    logic [PER_BITS-1:0]    pv;
    logic signed [PER_BITS-1:0] d;
    logic signed [GW-1:0]   at;
    logic [2*CB:0]          pr;

    // capture request
    st_nxt[1]           = '0;
    st_nxt[1].left      = GW'(in_rect_left);
    st_nxt[1].top       = GW'(in_rect_top);
    st_nxt[1].right     = GW'(in_rect_right);
    st_nxt[1].bottom    = GW'(in_rect_bottom);
    st_nxt[1].ln[0].per = in_used_per_mille;
    st_nxt[1].ln[1].per = in_cache_per_mille;

    // sizes, saturate used fraction, fold and quadrant
    st_nxt[2]   = st_r[1];
    st_nxt[2].h = st_r[1].bottom - st_r[1].top;
    st_nxt[2].w = st_r[1].right - st_r[1].left;
    for (int i = 0; i < 2; i++) begin
      pv = st_r[1].ln[i].per;
      if (i == 0 && pv > PER_BITS'(FULL_MILLE)) pv = PER_BITS'(FULL_MILLE);
      st_nxt[2].ln[i].per = pv;
      if (pv >= PER_BITS'(FULL_MILLE)) begin
        st_nxt[2].ln[i].r500 = 9'(pv - PER_BITS'(FULL_MILLE));
        st_nxt[2].ln[i].quad = QUAD_4;
      end else if (pv >= PER_BITS'(THREEQ_MILLE)) begin
        st_nxt[2].ln[i].r500 = 9'(pv - PER_BITS'(HALF_MILLE));
        st_nxt[2].ln[i].quad = QUAD_3;
      end else if (pv >= PER_BITS'(HALF_MILLE)) begin
        st_nxt[2].ln[i].r500 = 9'(pv - PER_BITS'(HALF_MILLE));
        st_nxt[2].ln[i].quad = QUAD_2;
      end else if (pv >= PER_BITS'(QUARTER_MILLE)) begin
        st_nxt[2].ln[i].r500 = 9'(pv);
        st_nxt[2].ln[i].quad = QUAD_1;
      end else begin
        st_nxt[2].ln[i].r500 = 9'(pv);
        st_nxt[2].ln[i].quad = QUAD_0;
      end
    end

    // fitted height, first-quadrant offsets
    st_nxt[3]    = st_r[2];
    st_nxt[3].th = ((st_r[2].h <<< 1) <= st_r[2].w) ? st_r[2].h : half_tz(st_r[2].w);
    for (int i = 0; i < 2; i++) begin
      d = $signed({1'b0, st_r[2].ln[i].r500}) - $signed(PER_BITS'(QUARTER_MILLE));
      st_nxt[3].ln[i].u = (d < 0) ? 8'(-d) : 8'(d);
      st_nxt[3].ln[i].v = 8'(QUARTER_MILLE) - st_nxt[3].ln[i].u;
    end

    // box origin, shadow magnitude prep, denominators
    st_nxt[4]      = st_r[3];
    st_nxt[4].bl   = st_r[3].left + half_tz(st_r[3].w - (st_r[3].th <<< 1));
    st_nxt[4].bt   = st_r[3].top + half_tz(st_r[3].h - st_r[3].th);
    st_nxt[4].neg  = st_r[3].th[GW-1];
    at             = st_r[3].th[GW-1] ? -st_r[3].th : st_r[3].th;
    st_nxt[4].mag2 = CB'(at >>> 1);
    for (int i = 0; i < 2; i++) begin
      st_nxt[4].ln[i].den   = 17'(st_r[3].ln[i].u) * 17'(st_r[3].ln[i].u)
                            + 17'(st_r[3].ln[i].v) * 17'(st_r[3].ln[i].v);
      st_nxt[4].ln[i].steep = (st_r[3].ln[i].u >= 8'(STEEP_LIMIT));
      st_nxt[4].ln[i].wt    = st_nxt[4].ln[i].steep ? st_r[3].ln[i].v : st_r[3].ln[i].u;
    end

    // divide by three through the reciprocal
    st_nxt[5]    = st_r[4];
    pr           = (2*CB+1)'(st_r[4].mag2) * (2*CB+1)'(RECIP);
    st_nxt[5].q3 = CB'(pr >> (CB + 1));

    // signed shadow, right edge, centre x
    st_nxt[6]        = st_r[5];
    st_nxt[6].shadow = st_r[5].neg ? -$signed(GW'(st_r[5].q3)) : $signed(GW'(st_r[5].q3));
    st_nxt[6].br     = st_r[5].bl + (st_r[5].th <<< 1);
    st_nxt[6].cx     = st_r[5].bl + st_r[5].th - ONE_G;

    // vertical radius, squared horizontal radius
    st_nxt[7]     = st_r[6];
    st_nxt[7].ry  = half_tz(st_r[6].th - st_r[6].shadow);
    st_nxt[7].rx2 = lo32(st_r[6].th) * lo32(st_r[6].th);

    // squared vertical radius, centre y, bottom edge, status
    st_nxt[8]        = st_r[7];
    st_nxt[8].ry2    = lo32(st_r[7].ry) * lo32(st_r[7].ry);
    st_nxt[8].cy     = st_r[7].bt + st_r[7].ry - ONE_G;
    st_nxt[8].bb     = st_r[7].bt + (st_r[7].ry <<< 1);
    st_nxt[8].status = !((st_r[7].th > MIN_R) && (st_r[7].ry > MIN_R));

    // pick axis order, first weight product
    st_nxt[9] = st_r[8];
    for (int i = 0; i < 2; i++) begin
      st_nxt[9].ln[i].a2 = st_r[8].ln[i].steep ? st_r[8].ry2 : st_r[8].rx2;
      st_nxt[9].ln[i].b2 = st_r[8].ln[i].steep ? st_r[8].rx2 : st_r[8].ry2;
      st_nxt[9].ln[i].p  = st_nxt[9].ln[i].a2 * WORD_BITS'(st_r[8].ln[i].wt);
    end

    // second weight product
    st_nxt[10] = st_r[9];
    for (int i = 0; i < 2; i++) begin
      st_nxt[10].ln[i].p = st_r[9].ln[i].p * WORD_BITS'(st_r[9].ln[i].wt);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 1; k <= NF; k++) v_r[k] <= 1'b0;
    end else begin
      v_r[1] <= start && !busy;
      for (int k = 2; k <= NF; k++) v_r[k] <= v_r[k-1];
    end
  end

  always_ff @(posedge clk) begin
    for (int k = 1; k <= NF; k++) st_r[k] <= st_nxt[k];
  end

  // ---------------- root lanes ----------------
  logic                 l_vld [2];
  logic [ROOT_BITS-1:0] l_r2  [2];
  side_t                l_sd  [2];

  for (genvar g = 0; g < 2; g++) begin : g_lane
    side_t                sd_in;
    logic                 d1_vld, s1_vld, d2_vld, s2_vld;
    logic [WORD_BITS-1:0] d1_q, d2_q;
    logic [ROOT_BITS-1:0] s1_root, s2_root;
    logic [SB-1:0]        d1_side, s1_side, d2_side, s2_side;
    logic                 x1_vld_r, x2_vld_r;
    logic [WORD_BITS-1:0] x1_sq_r, x2_b_r;
    side_t                x1_sd_r, x2_sd_r, x1_sd_nxt;

    always_comb begin
      sd_in        = '0;
      sd_in.bl     = CB'(st_r[NF].bl);
      sd_in.bt     = CB'(st_r[NF].bt);
      sd_in.br     = CB'(st_r[NF].br);
      sd_in.bb     = CB'(st_r[NF].bb);
      sd_in.sh     = CB'(st_r[NF].shadow);
      sd_in.cx     = st_r[NF].cx;
      sd_in.cy     = st_r[NF].cy;
      sd_in.status = st_r[NF].status;
      sd_in.a2     = st_r[NF].ln[g].a2;
      sd_in.b2     = st_r[NF].ln[g].b2;
      sd_in.steep  = st_r[NF].ln[g].steep;
      sd_in.quad   = st_r[NF].ln[g].quad;
    end

    pcsg_div #(.SW(SB)) u_div1 (
      .clk(clk), .rst_n(rst_n),
      .in_vld(v_r[NF]), .in_num(st_r[NF].ln[g].p),
      .in_den(WORD_BITS'(st_r[NF].ln[g].den)), .in_side(sd_in),
      .out_vld(d1_vld), .out_quo(d1_q), .out_side(d1_side)
    );

    pcsg_sqrt #(.SW(SB)) u_sqrt1 (
      .clk(clk), .rst_n(rst_n),
      .in_vld(d1_vld), .in_val(d1_q), .in_side(d1_side),
      .out_vld(s1_vld), .out_root(s1_root), .out_side(s1_side)
    );

    // keep first root, square it
    always_comb begin
      x1_sd_nxt    = side_t'(s1_side);
      x1_sd_nxt.r1 = s1_root;
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        x1_vld_r <= 1'b0;
        x2_vld_r <= 1'b0;
      end else begin
        x1_vld_r <= s1_vld;
        x2_vld_r <= x1_vld_r;
      end
    end

    // remaining square scaled by the other axis
    always_ff @(posedge clk) begin
      x1_sd_r <= x1_sd_nxt;
      x1_sq_r <= WORD_BITS'(s1_root) * WORD_BITS'(s1_root);
      x2_sd_r <= x1_sd_r;
      x2_b_r  <= (x1_sd_r.a2 - x1_sq_r) * x1_sd_r.b2;
    end

    pcsg_div #(.SW(SB)) u_div2 (
      .clk(clk), .rst_n(rst_n),
      .in_vld(x2_vld_r), .in_num(x2_b_r), .in_den(x2_sd_r.a2), .in_side(x2_sd_r),
      .out_vld(d2_vld), .out_quo(d2_q), .out_side(d2_side)
    );

    pcsg_sqrt #(.SW(SB)) u_sqrt2 (
      .clk(clk), .rst_n(rst_n),
      .in_vld(d2_vld), .in_val(d2_q), .in_side(d2_side),
      .out_vld(s2_vld), .out_root(s2_root), .out_side(s2_side)
    );

    assign l_vld[g] = s2_vld;
    assign l_r2[g]  = s2_root;
    assign l_sd[g]  = side_t'(s2_side);
  end

  // ---------------- point mapping and output register ----------------
  logic [CB-1:0]        px_nxt [2];
  logic signed [CB:0]   py_nxt [2];
  logic                 valid_r;
  logic signed [CB-1:0] bl_r, bt_r, br_r, bb_r, sh_r, cx_r, cy_r;
  logic [CB-1:0]        ux_r, kx_r;
  logic signed [CB:0]   uy_r, ky_r;
  logic                 status_r;

  always_comb begin
    logic [ROOT_BITS-1:0] xr, yr;
    logic signed [PW-1:0] xs, ys;
    for (int i = 0; i < 2; i++) begin
      xr = l_sd[i].steep ? l_r2[i] : l_sd[i].r1;
      yr = l_sd[i].steep ? l_sd[i].r1 : l_r2[i];
      xs = $signed(PW'(xr));
      ys = $signed(PW'(yr));
      case (l_sd[i].quad)
        QUAD_1:  ys = -ys;
        QUAD_2:  ;
        QUAD_3:  xs = -xs;
        default: begin
          xs = -xs;
          ys = -ys;
        end
      endcase
      xs = xs + PW'(l_sd[i].cx);
      ys = ys + PW'(l_sd[i].cy);
      if (xs < 0) xs = '0;
      if (l_sd[i].status) begin
        px_nxt[i] = '0;
        py_nxt[i] = '0;
      end else begin
        px_nxt[i] = CB'(xs);
        py_nxt[i] = (CB+1)'(ys);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= l_vld[0];
    end
  end

  always_ff @(posedge clk) begin
    bl_r     <= l_sd[0].bl;
    bt_r     <= l_sd[0].bt;
    br_r     <= l_sd[0].br;
    bb_r     <= l_sd[0].bb;
    sh_r     <= l_sd[0].sh;
    cx_r     <= CB'(l_sd[0].cx);
    cy_r     <= CB'(l_sd[0].cy);
    status_r <= l_sd[0].status;
    ux_r     <= px_nxt[0];
    uy_r     <= py_nxt[0];
    kx_r     <= px_nxt[1];
    ky_r     <= py_nxt[1];
  end

  assign out_valid        = valid_r;
  assign out_box_left     = bl_r;
  assign out_box_top      = bt_r;
  assign out_box_right    = br_r;
  assign out_box_bottom   = bb_r;
  assign out_shadow_depth = sh_r;
  assign out_centre_x     = cx_r;
  assign out_centre_y     = cy_r;
  assign out_used_x       = ux_r;
  assign out_used_y       = uy_r;
  assign out_cache_x      = kx_r;
  assign out_cache_y      = ky_r;
  assign out_status       = status_r;

  // ---------------- assertions ----------------
  `ASSERT_IMPLIES(a_lanes_aligned, clk, rst_n, 1'b1, l_vld[0] == l_vld[1])
  `ASSERT_IMPLIES(a_fixed_latency, clk, rst_n, out_valid, $past(start, LAT))
  `ASSERT_IMPLIES(a_small_zero_points, clk, rst_n, out_valid && out_status,
                  (out_used_x == '0) && (out_used_y == '0) &&
                  (out_cache_x == '0) && (out_cache_y == '0))
  `ASSERT_NEXT(a_front_to_lane, clk, rst_n, v_r[NF], g_lane[0].u_div1.vld_r[0])

endmodule

### sv/pcsg_div.sv
// Pipelined restoring divider, one quotient bit per stage, with sideband.
module pcsg_div import pcsg_pkg::*; #(
  parameter int SW = 1
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_vld,
  input  logic [WORD_BITS-1:0] in_num,
  input  logic [WORD_BITS-1:0] in_den,
  input  logic [SW-1:0]        in_side,
  output logic                 out_vld,
  output logic [WORD_BITS-1:0] out_quo,
  output logic [SW-1:0]        out_side
);

  logic                 vld_r  [DIV_STEPS];
  logic [WORD_BITS-1:0] rem_r  [DIV_STEPS];
  logic [WORD_BITS-1:0] nq_r   [DIV_STEPS];
  logic [WORD_BITS-1:0] den_r  [DIV_STEPS];
  logic [SW-1:0]        side_r [DIV_STEPS];

  for (genvar k = 0; k < DIV_STEPS; k++) begin : g_step
    logic                 p_vld;
    logic [WORD_BITS-1:0] p_rem, p_nq, p_den;
    logic [SW-1:0]        p_side;
    logic [WORD_BITS:0]   sh;
    logic                 ge;
    logic [WORD_BITS-1:0] rem_nxt, nq_nxt;

    if (k == 0) begin : g_first
      assign p_vld  = in_vld;
      assign p_rem  = '0;
      assign p_nq   = in_num;
      assign p_den  = in_den;
      assign p_side = in_side;
    end else begin : g_rest
      assign p_vld  = vld_r[k-1];
      assign p_rem  = rem_r[k-1];
      assign p_nq   = nq_r[k-1];
      assign p_den  = den_r[k-1];
      assign p_side = side_r[k-1];
    end

    // shift in next numerator bit, subtract when it fits
    always_comb begin
      sh      = {p_rem, p_nq[WORD_BITS-1]};
      ge      = (sh >= {1'b0, p_den});
      rem_nxt = ge ? WORD_BITS'(sh - {1'b0, p_den}) : sh[WORD_BITS-1:0];
      nq_nxt  = {p_nq[WORD_BITS-2:0], ge};
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[k] <= 1'b0;
      end else begin
        vld_r[k] <= p_vld;
      end
    end

    always_ff @(posedge clk) begin
      rem_r[k]  <= rem_nxt;
      nq_r[k]   <= nq_nxt;
      den_r[k]  <= p_den;
      side_r[k] <= p_side;
    end
  end

  assign out_vld  = vld_r[DIV_STEPS-1];
  assign out_quo  = nq_r[DIV_STEPS-1];
  assign out_side = side_r[DIV_STEPS-1];

endmodule

### sv/pcsg_sqrt.sv
// Pipelined integer square root, one root bit per stage, with sideband.
module pcsg_sqrt import pcsg_pkg::*; #(
  parameter int SW = 1
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_vld,
  input  logic [WORD_BITS-1:0] in_val,
  input  logic [SW-1:0]        in_side,
  output logic                 out_vld,
  output logic [ROOT_BITS-1:0] out_root,
  output logic [SW-1:0]        out_side
);

  localparam int RB = ROOT_BITS + 4;

  logic                 vld_r  [SQRT_STEPS];
  logic [RB-1:0]        rem_r  [SQRT_STEPS];
  logic [ROOT_BITS-1:0] root_r [SQRT_STEPS];
  logic [WORD_BITS-1:0] n_r    [SQRT_STEPS];
  logic [SW-1:0]        side_r [SQRT_STEPS];

  for (genvar k = 0; k < SQRT_STEPS; k++) begin : g_step
    logic                 p_vld;
    logic [RB-1:0]        p_rem;
    logic [ROOT_BITS-1:0] p_root;
    logic [WORD_BITS-1:0] p_n;
    logic [SW-1:0]        p_side;
    logic [RB-1:0]        rs, trial, rem_nxt;
    logic [ROOT_BITS-1:0] rt;
    logic                 ge;

    if (k == 0) begin : g_first
      assign p_vld  = in_vld;
      assign p_rem  = '0;
      assign p_root = '0;
      assign p_n    = in_val;
      assign p_side = in_side;
    end else begin : g_rest
      assign p_vld  = vld_r[k-1];
      assign p_rem  = rem_r[k-1];
      assign p_root = root_r[k-1];
      assign p_n    = n_r[k-1];
      assign p_side = side_r[k-1];
    end

    // bring down two bits, try root*4+1
    always_comb begin
      rs      = {p_rem[RB-3:0], p_n[WORD_BITS-1:WORD_BITS-2]};
      rt      = {p_root[ROOT_BITS-2:0], 1'b0};
      trial   = RB'({rt, 1'b1});
      ge      = (rs >= trial);
      rem_nxt = ge ? (rs - trial) : rs;
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[k] <= 1'b0;
      end else begin
        vld_r[k] <= p_vld;
      end
    end

    always_ff @(posedge clk) begin
      rem_r[k]  <= rem_nxt;
      root_r[k] <= {rt[ROOT_BITS-1:1], ge};
      n_r[k]    <= {p_n[WORD_BITS-3:0], 2'b00};
      side_r[k] <= p_side;
    end
  end

  assign out_vld  = vld_r[SQRT_STEPS-1];
  assign out_root = root_r[SQRT_STEPS-1];
  assign out_side = side_r[SQRT_STEPS-1];

endmodule

### verif/testbench.sv
// Self-checking testbench for the pie chart sector geometry block.
`timescale 1ns / 100ps

module testbench import pcsg_pkg::*; ();

  localparam int CB = COORD_BITS_DEF;
  localparam int LATENCY = 109;
  localparam int STALL_LIMIT = 4000;
  localparam int RAND_ITEMS = 600;

  typedef struct {
    logic signed [CB-1:0] left, top, right, bottom;
    logic [PER_BITS-1:0]  used, cache;
  } rect_req_t;

  typedef struct {
    logic signed [CB-1:0] box_left, box_top, box_right, box_bottom;
    logic signed [CB-1:0] shadow, cx, cy;
    logic [CB-1:0]        used_x;
    logic signed [CB:0]   used_y;
    logic [CB-1:0]        cache_x;
    logic signed [CB:0]   cache_y;
    logic                 status;
  } geom_t;

  typedef struct {
    rect_req_t rq;
    bit        typed;
    geom_t     ex;
  } stim_row_t;

  logic      clk;
  logic      rst_n;
  logic      start;
  logic      busy;
  rect_req_t drv;
  bit        drv_typed;
  geom_t     drv_ex;
  logic      out_valid;
  geom_t     got;

  geom_t     geom_q[$];
  int        n_acc;
  int        n_ok;
  int        n_small;
  int        errs;
  int        stall_cyc;

  pie_chart_sector_geometry u_top (
    .clk               (clk),
    .rst_n             (rst_n),
    .start             (start),
    .busy              (busy),
    .in_rect_left      (drv.left),
    .in_rect_top       (drv.top),
    .in_rect_right     (drv.right),
    .in_rect_bottom    (drv.bottom),
    .in_used_per_mille (drv.used),
    .in_cache_per_mille(drv.cache),
    .out_valid         (out_valid),
    .out_box_left      (got.box_left),
    .out_box_top       (got.box_top),
    .out_box_right     (got.box_right),
    .out_box_bottom    (got.box_bottom),
    .out_shadow_depth  (got.shadow),
    .out_centre_x      (got.cx),
    .out_centre_y      (got.cy),
    .out_used_x        (got.used_x),
    .out_used_y        (got.used_y),
    .out_cache_x       (got.cache_x),
    .out_cache_y       (got.cache_y),
    .out_status        (got.status)
  );

  // 8 ns clock
  always begin
    clk = 1'b1;
    #4;
    clk = 1'b0;
    #4;
  end

  // Bitwise integer square root, 16 steps
  function automatic int unsigned root16(int unsigned n);
    int unsigned root, rem, trial;
    root = 0;
    rem = 0;
    for (int k = 0; k < SQRT_STEPS; k++) begin
      rem = (rem << 2) | (n >> 30);
      root = root << 1;
      trial = (root << 1) + 1;
      if (rem >= trial) begin
        rem = rem - trial;
        root = root | 1;
      end
      n = n << 2;
    end
    return root;
  endfunction

  // Boundary point of the ellipse for one fraction, with 32-bit wrapping roots
  function automatic void ellipse_point(int unsigned per, longint rx, longint ry,
                                        longint cx, longint cy,
                                        output longint px, output longint py);
    longint      q, x, y;
    int unsigned u, v, den, rx2, ry2, xr, yr, a, b;
    q = longint'(per % HALF_MILLE) - QUARTER_MILLE;
    if (q < 0) q = -q;
    u = 32'(q);
    v = QUARTER_MILLE - u;
    a = 32'(rx);
    b = 32'(ry);
    rx2 = a * a;
    ry2 = b * b;
    den = u * u + v * v;
    if (u < STEEP_LIMIT) begin
      xr = root16((rx2 * u * u) / den);
      yr = root16(((rx2 - xr * xr) * ry2) / rx2);
    end else begin
      yr = root16((ry2 * v * v) / den);
      xr = root16(((ry2 - yr * yr) * rx2) / ry2);
    end
    x = longint'(xr);
    y = longint'(yr);
    case (3'(per / QUARTER_MILLE))
      QUAD_1: y = -y;
      QUAD_2: ;
      QUAD_3: x = -x;
      default: begin
        x = -x;
        y = -y;
      end
    endcase
    x = x + cx;
    y = y + cy;
    if (x < 0) x = 0;
    px = x;
    py = y;
  endfunction

  // Fit the 2:1 box and derive both sector points
  function automatic geom_t sector_geom(rect_req_t q);
    longint      h, w, th, tw, bt, bl, sh, rx, ry, cx, cy, ux, uy, kx, ky;
    int unsigned used;
    geom_t       r;
    h = longint'(q.bottom) - longint'(q.top);
    w = longint'(q.right) - longint'(q.left);
    th = (h * 2 <= w) ? h : w / 2;
    tw = th * 2;
    bt = longint'(q.top) + (h - th) / 2;
    bl = longint'(q.left) + (w - tw) / 2;
    sh = th / 6;
    rx = tw / 2;
    ry = (th - sh) / 2;
    cx = bl + rx - 1;
    cy = bt + ry - 1;
    ux = 0; uy = 0; kx = 0; ky = 0;
    used = (q.used > FULL_MILLE) ? FULL_MILLE : q.used;
    r.status = 1'b1;
    if (rx > MIN_RADIUS && ry > MIN_RADIUS) begin
      r.status = 1'b0;
      ellipse_point(used, rx, ry, cx, cy, ux, uy);
      ellipse_point(32'(q.cache), rx, ry, cx, cy, kx, ky);
    end
    r.box_left   = bl[CB-1:0];
    r.box_top    = bt[CB-1:0];
    r.box_right  = 16'(bl + 2 * rx);
    r.box_bottom = 16'(bt + 2 * ry);
    r.shadow     = sh[CB-1:0];
    r.cx         = cx[CB-1:0];
    r.cy         = cy[CB-1:0];
    r.used_x     = ux[CB-1:0];
    r.used_y     = uy[CB:0];
    r.cache_x    = kx[CB-1:0];
    r.cache_y    = ky[CB:0];
    return r;
  endfunction

  task automatic chk(string nm, longint e, longint a);
    if (e != a) begin
      $display("%0t: %s mismatch: expected %0d, got %0d", $time, nm, e, a);
      errs++;
    end
  endtask

  // Accept requests, check results, watch for a stall
  always @(posedge clk) begin
    geom_t e;
    if (rst_n) begin
      if (start && !busy) begin
        geom_q.push_back(drv_typed ? drv_ex : sector_geom(drv));
        n_acc <= n_acc + 1;
      end
      if (out_valid) begin
        if (geom_q.size() == 0) begin
          $display("%0t: result with no request pending", $time);
          errs++;
        end else begin
          e = geom_q.pop_front();
          chk("box_left", e.box_left, got.box_left);
          chk("box_top", e.box_top, got.box_top);
          chk("box_right", e.box_right, got.box_right);
          chk("box_bottom", e.box_bottom, got.box_bottom);
          chk("shadow_depth", e.shadow, got.shadow);
          chk("centre_x", e.cx, got.cx);
          chk("centre_y", e.cy, got.cy);
          chk("used_x", e.used_x, got.used_x);
          chk("used_y", e.used_y, got.used_y);
          chk("cache_x", e.cache_x, got.cache_x);
          chk("cache_y", e.cache_y, got.cache_y);
          chk("status", e.status, got.status);
          if (got.status) n_small++;
          else n_ok++;
        end
      end
      if ((start && !busy) || out_valid) stall_cyc <= 0;
      else stall_cyc <= stall_cyc + 1;
      if (stall_cyc >= STALL_LIMIT) begin
        $display("%0t: no progress for %0d cycles", $time, STALL_LIMIT);
        $display("testbench: FAIL");
        $finish;
      end
    end
  end

  // Drive one request after a random gap; hold it until accepted
  task automatic send(stim_row_t rw, int idle_pct);
    int n;
    while ($urandom_range(0, 99) < idle_pct) begin
      start <= 1'b0;
      @(negedge clk);
    end
    drv       <= rw.rq;
    drv_typed <= rw.typed;
    drv_ex    <= rw.ex;
    start     <= 1'b1;
    n = n_acc;
    do @(negedge clk); while (n_acc == n);
  endtask

  function automatic stim_row_t plain(int l, int t, int r, int b, int u, int c);
    stim_row_t s;
    s.rq = '{16'(l), 16'(t), 16'(r), 16'(b), 10'(u), 10'(c)};
    s.typed = 1'b0;
    s.ex = '{default: '0};
    return s;
  endfunction

  // Random rectangle: mostly well formed, some raw noise
  function automatic stim_row_t rand_row();
    stim_row_t s;
    int        w, h, l, t;
    s = plain(0, 0, 0, 0, $urandom_range(0, 1023), $urandom_range(0, 1023));
    if ($urandom_range(0, 99) < 25) begin
      s.rq.left   = CB'($urandom);
      s.rq.top    = CB'($urandom);
      s.rq.right  = CB'($urandom);
      s.rq.bottom = CB'($urandom);
    end else begin
      case ($urandom_range(0, 9))
        0: w = $urandom_range(0, 65535);
        1, 2: w = $urandom_range(20, 3000);
        default: w = $urandom_range(15, 120);
      endcase
      h = $urandom_range(0, 99) < 50 ? w / 2 + $urandom_range(0, 40) - 20
                                     : $urandom_range(0, w);
      if (h < 0) h = 0;
      l = $urandom_range(0, 65535 - w) - 32768;
      t = $urandom_range(0, 65535 - h) - 32768;
      s.rq.left   = CB'(l);
      s.rq.right  = CB'(l + w);
      s.rq.top    = CB'(t);
      s.rq.bottom = CB'(t + h);
    end
    return s;
  endfunction

  initial begin
    stim_row_t dir_tab[$];
    stim_row_t s;
    int        tail;
    rst_n = 1'b0;
    start = 1'b0;
    drv = '{default: '0};
    drv_typed = 1'b0;
    drv_ex = '{default: '0};
    n_acc = 0; n_ok = 0; n_small = 0; errs = 0; stall_cyc = 0;

    // Directed table: empty rectangle and a plain 200x100 box are typed in
    s = plain(0, 0, 0, 0, 0, 0);
    s.typed = 1'b1;
    s.ex = '{16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0, -16'sd1, -16'sd1,
             16'd0, 17'sd0, 16'd0, 17'sd0, 1'b1};
    dir_tab.push_back(s);
    s = plain(0, 0, 200, 100, 0, 0);
    s.typed = 1'b1;
    s.ex = '{16'sd0, 16'sd0, 16'sd200, 16'sd84, 16'sd16, 16'sd99, 16'sd41,
             16'd0, 17'sd41, 16'd0, 17'sd41, 1'b0};
    dir_tab.push_back(s);
    // quadrants one to four, saturation of used, cache above full
    dir_tab.push_back(plain(0, 0, 200, 100, 1000, 1000));
    dir_tab.push_back(plain(0, 0, 200, 100, 1023, 1023));
    dir_tab.push_back(plain(0, 0, 200, 100, 250, 500));
    dir_tab.push_back(plain(0, 0, 200, 100, 750, 999));
    dir_tab.push_back(plain(0, 0, 200, 100, 1001, 1001));
    // steep branch edges
    dir_tab.push_back(plain(-50, 30, 150, 130, 130, 131));
    dir_tab.push_back(plain(-50, 30, 150, 130, 370, 371));
    dir_tab.push_back(plain(-50, 30, 150, 130, 630, 871));
    // radius threshold on both sides
    dir_tab.push_back(plain(0, 0, 20, 10, 100, 100));
    dir_tab.push_back(plain(0, 0, 50, 25, 100, 100));
    dir_tab.push_back(plain(0, 0, 52, 26, 100, 100));
    // inverted and tall rectangles
    dir_tab.push_back(plain(100, 100, 0, 0, 300, 600));
    dir_tab.push_back(plain(0, 0, 100, 1000, 600, 300));
    // coordinate extremes, where the square-root operands wrap
    dir_tab.push_back(plain(-32768, -32768, 32767, 32767, 125, 875));
    dir_tab.push_back(plain(32767, 32767, -32768, -32768, 0, 1023));
    dir_tab.push_back(plain(-32768, 0, 32767, 1000, 511, 512));
    dir_tab.push_back(plain(-32768, -32768, 32767, -16384, 1, 1022));
    dir_tab.push_back(plain(32767, -32768, 32767, 32767, 682, 341));

    repeat (11) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    foreach (dir_tab[i]) send(dir_tab[i], 25);
    for (int i = 0; i < RAND_ITEMS; i++)
      send(rand_row(), i < RAND_ITEMS / 3 ? 25 : (i < 2 * RAND_ITEMS / 3 ? 55 : 0));
    start <= 1'b0;
    drv_typed <= 1'b0;

    // Drain the pipe, then allow for any stray strobe
    while (geom_q.size() != 0) @(negedge clk);
    tail = 0;
    while (tail < LATENCY + 20) begin
      @(negedge clk);
      tail++;
    end
    if (geom_q.size() != 0) begin
      $display("%0d expected results never arrived", geom_q.size());
      errs++;
    end

    $display("Ran %0d requests: %0d drawn normally, %0d flagged with too small a radius.",
             n_acc, n_ok, n_small);
    $display("Field mismatches or stray results seen: %0d", errs);
    if (errs == 0) begin
      $display("testbench: PASS");
    end else begin
      $display("testbench: FAIL");
    end
    $finish;
  end

endmodule
